// ===== hdl/dual_vca_linear_exponential_cv_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual VCA block
// Each macro expects clk and rst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef DUAL_VCA_LINEAR_EXPONENTIAL_CV_DEFINES_SVH
`define DUAL_VCA_LINEAR_EXPONENTIAL_CV_DEFINES_SVH

// An implication checked at every rising edge outside reset.
`define DVCA_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A condition that holds at every rising edge outside reset.
`define DVCA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

// ===== hdl/dvca_pkg.sv =====
// ----------------------------------------------------------------------------
// dvca_pkg
// Shared widths, register codes, the configuration struct and the
// exponential curve table of the dual VCA.
// ----------------------------------------------------------------------------
`default_nettype none

package dvca_pkg;

  localparam int SAMPLE_BITS      = 16;
  localparam int CV_BITS          = 16;
  localparam int CV_FRAC_BITS     = 15;
  localparam int LEVEL_BITS       = 17;
  localparam int GAIN_BITS        = 17;
  localparam int CURVE_TABLE_BITS = 8;
  localparam int CURVE_FRAC_BITS  = CV_FRAC_BITS - CURVE_TABLE_BITS;
  localparam int CURVE_POINTS     = 1 << CURVE_TABLE_BITS;
  localparam int CURVE_WORD_BITS  = 16;
  localparam int PROD_BITS        = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int OUT_SHIFT        = 16;
  localparam int CFG_INDEX_BITS   = 3;
  localparam int CFG_DATA_BITS    = 17;

  localparam logic [LEVEL_BITS-1:0]      UNITY_Q16 = LEVEL_BITS'(65536);
  localparam logic [CURVE_WORD_BITS-1:0] UNITY_Q15 = CURVE_WORD_BITS'(32768);

  localparam longint unsigned ONE_Q24      = 64'd16777216;
  localparam longint unsigned LN50_Q24     = 64'd65632855;
  localparam int unsigned     SERIES_TERMS = 40;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LEVEL_FIRST       = 3'd0,
    REG_LEVEL_SECOND      = 3'd1,
    REG_LIN_ENABLE_FIRST  = 3'd2,
    REG_EXP_ENABLE_FIRST  = 3'd3,
    REG_LIN_ENABLE_SECOND = 3'd4,
    REG_EXP_ENABLE_SECOND = 3'd5
  } dvca_reg_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level_first;
    logic [LEVEL_BITS-1:0] level_second;
    logic                  lin_enable_first;
    logic                  exp_enable_first;
    logic                  lin_enable_second;
    logic                  exp_enable_second;
  } dvca_cfg_t;

  typedef logic [CURVE_WORD_BITS-1:0] curve_word_t;
  typedef curve_word_t curve_tbl_t [CURVE_POINTS];

  // Unsigned quotient by shift and subtract; used only while the curve table
  // is built at elaboration.
  function automatic longint unsigned div_u64(input longint unsigned n,
                                              input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Points of (50^x - 1) / 49 at x = i / CURVE_POINTS in Q15. The series for
  // e^t is summed in Q24 with truncating terms; evaluated at elaboration.
  function automatic curve_tbl_t build_curve();
    curve_tbl_t        tbl;
    longint unsigned   t;
    longint unsigned   term;
    longint unsigned   sum;
    longint unsigned   num;
    tbl[0] = '0;
    for (int i = 1; i < CURVE_POINTS; i++) begin
      t    = (LN50_Q24 * longint'(i)) >> CURVE_TABLE_BITS;
      term = ONE_Q24;
      sum  = ONE_Q24;
      for (int unsigned k = 1; k <= SERIES_TERMS; k++) begin
        term = div_u64(term * t, longint'(k) * ONE_Q24);
        sum  = sum + term;
      end
      num = (sum - ONE_Q24) * 64'd32768 + ((64'd49 * ONE_Q24) >> 1);
      num = div_u64(num, 64'd49 * ONE_Q24);
      if (num > 64'd32768) begin
        num = 64'd32768;
      end
      tbl[i] = curve_word_t'(num);
    end
    return tbl;
  endfunction

  localparam curve_tbl_t CURVE_TBL = build_curve();

endpackage

`default_nettype wire

// ===== hdl/dvca_regs.sv =====
// ----------------------------------------------------------------------------
// dvca_regs
// Configuration register file: levels with saturation to unity and the
// per-channel enable bits.
// ----------------------------------------------------------------------------
`default_nettype none

module dvca_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dvca_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [dvca_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output dvca_pkg::dvca_cfg_t                      cfg
);
  import dvca_pkg::*;

  dvca_cfg_t             cfg_r;
  logic [LEVEL_BITS-1:0] level_sat;

  // Writes are always taken; cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  always_comb begin
    level_sat = cfg_data[LEVEL_BITS-1:0];
    if (level_sat > UNITY_Q16) begin
      level_sat = UNITY_Q16;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_first       <= UNITY_Q16;
      cfg_r.level_second      <= UNITY_Q16;
      cfg_r.lin_enable_first  <= 1'b0;
      cfg_r.exp_enable_first  <= 1'b0;
      cfg_r.lin_enable_second <= 1'b0;
      cfg_r.exp_enable_second <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LEVEL_FIRST:       cfg_r.level_first       <= level_sat;
        REG_LEVEL_SECOND:      cfg_r.level_second      <= level_sat;
        REG_LIN_ENABLE_FIRST:  cfg_r.lin_enable_first  <= cfg_data[0];
        REG_EXP_ENABLE_FIRST:  cfg_r.exp_enable_first  <= cfg_data[0];
        REG_LIN_ENABLE_SECOND: cfg_r.lin_enable_second <= cfg_data[0];
        REG_EXP_ENABLE_SECOND: cfg_r.exp_enable_second <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hdl/dual_vca_linear_exponential_cv.sv =====
// ----------------------------------------------------------------------------
// dual_vca_linear_exponential_cv
// Two-channel VCA with linear and exponential control voltages, pipelined.
// ----------------------------------------------------------------------------
// Usage:
// An input transaction is taken at a rising edge where start is high and busy
// is low. It carries the channel select, one audio sample and the linear and
// exponential control voltages for that voice. Busy is high only in the cycle
// after a reset edge; otherwise the block takes a transaction every cycle.
// Each transaction gives one result, shown on out_audio_out for one cycle with
// out_valid high, once it has passed through every register stage. The
// receiver cannot stall the block, so nothing is held back on the result side.
// Throughput is one sample per cycle while busy is low; the
// five register stages are: table lookup, curve interpolation with the linear
// gain, the exponential gain, the sample multiply and the truncating rescale.
// Reset clears all valid bits, so transactions in flight are dropped, and puts
// both levels at unity with every control-voltage enable off. Configuration
// writes are always taken (cfg_ready is always high); the user makes them only
// while no transaction is in flight, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_vca_linear_exponential_cv (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  // Input transaction
  input  wire logic                                    start,
  output logic                                         busy,
  input  wire logic                                    in_channel_select,
  input  wire logic signed [dvca_pkg::SAMPLE_BITS-1:0] in_audio_in,
  input  wire logic signed [dvca_pkg::CV_BITS-1:0]     in_lin_voltage,
  input  wire logic signed [dvca_pkg::CV_BITS-1:0]     in_exp_voltage,
  // Result transaction
  output logic                                         out_valid,
  output logic signed [dvca_pkg::SAMPLE_BITS-1:0]      out_audio_out,
  // Configuration writes
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [dvca_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [dvca_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import dvca_pkg::*;

  localparam logic [CURVE_TABLE_BITS-1:0] LAST_SEG = '1;
  localparam logic signed [PROD_BITS-1:0] TRUNC_BIAS =
    PROD_BITS'((64'd1 << OUT_SHIFT) - 64'd1);

  dvca_cfg_t cfg;

  dvca_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Busy only right after a reset edge.
  logic busy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end
  assign busy = busy_r;

  logic accept;
  assign accept = start && !busy_r;

  // ---------------- Stage 1: channel select, clamping, table lookup --------
  logic [LEVEL_BITS-1:0]       level_sel;
  logic                        use_lin_sel;
  logic                        use_exp_sel;
  logic [CV_FRAC_BITS-1:0]     lin_clamp;
  logic [CV_FRAC_BITS-1:0]     exp_clamp;
  logic [CURVE_TABLE_BITS-1:0] seg;
  logic [CURVE_TABLE_BITS-1:0] seg_next;
  logic [CURVE_WORD_BITS-1:0]  p0;
  logic [CURVE_WORD_BITS-1:0]  p1;
  logic [CURVE_WORD_BITS-1:0]  delta;

  always_comb begin
    level_sel   = in_channel_select ? cfg.level_second      : cfg.level_first;
    use_lin_sel = in_channel_select ? cfg.lin_enable_second : cfg.lin_enable_first;
    use_exp_sel = in_channel_select ? cfg.exp_enable_second : cfg.exp_enable_first;
    // A negative control voltage clamps to zero.
    lin_clamp = in_lin_voltage[CV_BITS-1] ? '0 : in_lin_voltage[CV_FRAC_BITS-1:0];
    exp_clamp = in_exp_voltage[CV_BITS-1] ? '0 : in_exp_voltage[CV_FRAC_BITS-1:0];
    seg       = exp_clamp[CV_FRAC_BITS-1:CURVE_FRAC_BITS];
    seg_next  = seg + 1'b1;
    p0        = CURVE_TBL[seg];
    // The top segment ends at the full-scale point, which is not in the table.
    p1        = (seg == LAST_SEG) ? UNITY_Q15 : CURVE_TBL[seg_next];
    delta     = (p1 >= p0) ? (p1 - p0) : '0;
  end

  logic                              s1_valid_r;
  logic signed [SAMPLE_BITS-1:0]     s1_sample_r;
  logic [LEVEL_BITS-1:0]             s1_level_r;
  logic                              s1_use_lin_r;
  logic                              s1_use_exp_r;
  logic [CV_FRAC_BITS-1:0]           s1_lin_r;
  logic [CURVE_WORD_BITS-1:0]        s1_p0_r;
  logic [CURVE_WORD_BITS-1:0]        s1_delta_r;
  logic [CURVE_FRAC_BITS-1:0]        s1_frac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_sample_r  <= in_audio_in;
    s1_level_r   <= level_sel;
    s1_use_lin_r <= use_lin_sel;
    s1_use_exp_r <= use_exp_sel;
    s1_lin_r     <= lin_clamp;
    s1_p0_r      <= p0;
    s1_delta_r   <= delta;
    s1_frac_r    <= exp_clamp[CURVE_FRAC_BITS-1:0];
  end

  // ---------------- Stage 2: interpolation and linear gain -----------------
  logic [CURVE_WORD_BITS+CURVE_FRAC_BITS-1:0] interp_prod;
  logic [CURVE_WORD_BITS-1:0]                 curve_val;
  logic [LEVEL_BITS+CV_FRAC_BITS-1:0]         lin_prod;
  logic [GAIN_BITS-1:0]                       gain_lin;

  always_comb begin
    interp_prod = s1_delta_r * s1_frac_r;
    curve_val   = s1_p0_r + interp_prod[CURVE_WORD_BITS+CURVE_FRAC_BITS-1:CURVE_FRAC_BITS];
    lin_prod    = s1_level_r * s1_lin_r;
    gain_lin    = s1_use_lin_r ? lin_prod[CV_FRAC_BITS +: GAIN_BITS] : s1_level_r;
  end

  logic                          s2_valid_r;
  logic signed [SAMPLE_BITS-1:0] s2_sample_r;
  logic                          s2_use_exp_r;
  logic [GAIN_BITS-1:0]          s2_gain_r;
  logic [CURVE_WORD_BITS-1:0]    s2_curve_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_sample_r  <= s1_sample_r;
    s2_use_exp_r <= s1_use_exp_r;
    s2_gain_r    <= gain_lin;
    s2_curve_r   <= curve_val;
  end

  // ---------------- Stage 3: exponential gain ------------------------------
  logic [GAIN_BITS+CURVE_WORD_BITS-1:0] exp_prod;
  logic [GAIN_BITS-1:0]                 gain_exp;

  always_comb begin
    exp_prod = s2_gain_r * s2_curve_r;
    gain_exp = s2_use_exp_r ? exp_prod[CV_FRAC_BITS +: GAIN_BITS] : s2_gain_r;
  end

  logic                          s3_valid_r;
  logic signed [SAMPLE_BITS-1:0] s3_sample_r;
  logic [GAIN_BITS-1:0]          s3_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_sample_r <= s2_sample_r;
    s3_gain_r   <= gain_exp;
  end

  // ---------------- Stage 4: sample times gain -----------------------------
  logic signed [GAIN_BITS:0]     gain_signed;
  logic signed [PROD_BITS-1:0]   sample_prod;

  always_comb begin
    gain_signed = $signed({1'b0, s3_gain_r});
    sample_prod = s3_sample_r * gain_signed;
  end

  logic                        s4_valid_r;
  logic signed [PROD_BITS-1:0] s4_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_prod_r <= sample_prod;
  end

  // ---------------- Stage 5: divide by 65536 toward zero -------------------
  // A negative product gets a bias of 65535 before the arithmetic shift.
  logic signed [PROD_BITS-1:0] prod_biased;

  always_comb begin
    prod_biased = s4_prod_r + (s4_prod_r[PROD_BITS-1] ? TRUNC_BIAS : '0);
  end

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_audio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_audio_r <= prod_biased[OUT_SHIFT +: SAMPLE_BITS];
  end

  assign out_valid     = out_valid_r;
  assign out_audio_out = out_audio_r;

endmodule

`default_nettype wire

// ===== hdl/dvca_checker.sv =====
// ----------------------------------------------------------------------------
// dvca_checker
// Port-level checks of the dual VCA: latency, busy after reset, a silent
// sample giving silence and the sign of the result; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_vca_linear_exponential_cv_defines.svh"

module dvca_checker (
  input wire logic                                    clk,
  input wire logic                                    rst_n,
  input wire logic                                    start,
  input wire logic                                    busy,
  input wire logic signed [dvca_pkg::SAMPLE_BITS-1:0] in_audio_in,
  input wire logic                                    out_valid,
  input wire logic signed [dvca_pkg::SAMPLE_BITS-1:0] out_audio_out
);
  import dvca_pkg::*;

  logic       accept;
  logic       quiet_run;
  logic [4:0] rst_hist_r;

  assign accept = start && !busy;

  // Reset as sampled into a five-bit history register.
  always_ff @(posedge clk) begin
    rst_hist_r <= {rst_hist_r[3:0], rst_n};
  end

  // No reset edge between an accepted transaction and its result.
  assign quiet_run = &rst_hist_r;

  `DVCA_ASSERT_IMPLIES(a_result_has_source, out_valid, $past(accept, 5), "result without a transaction five cycles earlier")
  `DVCA_ASSERT_IMPLIES(a_transaction_gives_result, $past(accept, 5) && quiet_run, out_valid, "transaction lost in the pipeline")
  `DVCA_ASSERT_ALWAYS(a_busy_clears, !$past(rst_n) || !busy, "busy high outside the cycle after reset")
  `DVCA_ASSERT_IMPLIES(a_zero_in_zero_out, out_valid && $past(in_audio_in == '0, 5), out_audio_out == '0, "silent sample gave a nonzero result")
  `DVCA_ASSERT_IMPLIES(a_sign_kept, out_valid && out_audio_out != '0, out_audio_out[SAMPLE_BITS-1] == $past(in_audio_in[SAMPLE_BITS-1], 5), "result sign differs from sample sign")

endmodule

bind dual_vca_linear_exponential_cv dvca_checker u_dvca_checker (.*);

`default_nettype wire

// ===== test/dual_vca_linear_exponential_cv_test.sv =====
// ----------------------------------------------------------------------------
// dual_vca_linear_exponential_cv_test
// Self-checking bench for the two-channel VCA. Samples go in through the
// start/busy port, and each amplified sample coming back on out_valid is
// compared with an output computed here from the bench's own copy of the level
// and enable registers and its own exponential curve table.
// ----------------------------------------------------------------------------
module dual_vca_linear_exponential_cv_test;
  import dvca_pkg::*;

  // Five register stages from the accepting edge to the result strobe.
  localparam int PIPE_LATENCY  = 5;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int REPORT_LIMIT  = 10;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_SAMPLES = 125;

  // Register indexes past the end of the register list; writes there are
  // dropped by the block.
  localparam logic [CFG_INDEX_BITS-1:0] SPARE_INDEX_LOW  = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] SPARE_INDEX_HIGH = 3'd7;

  // Fixed-point constants of the exponential curve: 1.0 and ln(50) in Q24.
  localparam longint unsigned Q24_UNIT     = 64'd16777216;
  localparam longint unsigned LOG50_Q24    = 64'd65632855;
  localparam int unsigned     TAYLOR_TERMS = 40;
  localparam int unsigned     Q15_UNIT     = 32768;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [CV_BITS-1:0]     cv_t;
  typedef logic [CV_FRAC_BITS-1:0]       cv_q15_t;

  // One accepted voice sample and the output it must produce.
  typedef struct {
    logic    second;
    sample_t audio;
    cv_t     lin_cv;
    cv_t     exp_cv;
    sample_t audio_out;
  } vca_expect_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_channel_select;
  sample_t                   in_audio_in;
  cv_t                       in_lin_voltage;
  cv_t                       in_exp_voltage;
  logic                      out_valid;
  sample_t                   out_audio_out;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  // The bench's own view of the configuration registers.
  logic [LEVEL_BITS-1:0] knob_first;
  logic [LEVEL_BITS-1:0] knob_second;
  logic                  lin_on_first;
  logic                  exp_on_first;
  logic                  lin_on_second;
  logic                  exp_on_second;

  // Points of (50^x - 1) / 49 in Q15, one more than the segment count so that
  // the last segment has an upper end.
  logic [15:0] exp_points [0:CURVE_POINTS];

  vca_expect_t out_expected_q [$];
  vca_expect_t oldest;
  int          error_count;
  int          samples_checked;
  int          reg_write_count;
  int          setting_count;
  longint      cycle_count;

  dual_vca_linear_exponential_cv u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_channel_select (in_channel_select),
    .in_audio_in       (in_audio_in),
    .in_lin_voltage    (in_lin_voltage),
    .in_exp_voltage    (in_exp_voltage),
    .out_valid         (out_valid),
    .out_audio_out     (out_audio_out),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The curve points: t = x * ln 50 in Q24, e^t summed as a truncating Taylor
  // series, then (e^t - 1) / 49 rounded half up into Q15. The two end points
  // are exact.
  initial begin : build_exp_points
    longint unsigned arg;
    longint unsigned term;
    longint unsigned total;
    longint unsigned scaled;
    exp_points[0]            = 16'd0;
    exp_points[CURVE_POINTS] = 16'(Q15_UNIT);
    for (int i = 1; i < CURVE_POINTS; i++) begin
      arg   = (LOG50_Q24 * longint'(i)) >> CURVE_TABLE_BITS;
      term  = Q24_UNIT;
      total = Q24_UNIT;
      for (int unsigned k = 1; k <= TAYLOR_TERMS; k++) begin
        term  = (term * arg) / (longint'(k) * Q24_UNIT);
        total = total + term;
      end
      scaled = ((total - Q24_UNIT) * Q15_UNIT + (64'd49 * Q24_UNIT) / 2)
               / (64'd49 * Q24_UNIT);
      if (scaled > Q15_UNIT) begin
        scaled = Q15_UNIT;
      end
      exp_points[i] = 16'(scaled);
    end
  end

  // A negative control voltage means no gain at all.
  function automatic cv_q15_t cv_to_q15(input cv_t cv);
    return cv[CV_BITS-1] ? '0 : cv_q15_t'(cv);
  endfunction

  // Exponential gain in Q15: the top bits of the voltage pick a segment of
  // the curve and the low bits interpolate linearly inside it.
  function automatic logic [15:0] exp_gain(input cv_q15_t c);
    int unsigned seg;
    int unsigned frac;
    int unsigned p0;
    int unsigned p1;
    int unsigned rise;
    seg  = c >> CURVE_FRAC_BITS;
    frac = c & ((1 << CURVE_FRAC_BITS) - 1);
    p0   = exp_points[seg];
    p1   = exp_points[seg + 1];
    rise = (p1 >= p0) ? p1 - p0 : 0;
    return 16'(p0 + ((rise * frac) >> CURVE_FRAC_BITS));
  endfunction

  // Output of one voice sample under the current register settings. The gain
  // starts from the level in Q16; each enabled control voltage scales it by a
  // Q15 factor with truncation. The final divide by 2^16 rounds toward zero.
  function automatic sample_t amplify(input logic second, input sample_t x,
                                      input cv_t lin_cv, input cv_t exp_cv);
    longint unsigned gain;
    longint          wide_sample;
    longint          wide_gain;
    gain = second ? knob_second : knob_first;
    if (second ? lin_on_second : lin_on_first) begin
      gain = (gain * cv_to_q15(lin_cv)) >> 15;
    end
    if (second ? exp_on_second : exp_on_first) begin
      gain = (gain * exp_gain(cv_to_q15(exp_cv))) >> 15;
    end
    wide_sample = x;
    wide_gain   = gain;
    return sample_t'((wide_sample * wide_gain) / 64'sd65536);
  endfunction

  // Mirror of a register write. Levels are masked to their width and then
  // saturate at unity; an enable takes only bit 0; unknown indexes do nothing.
  task automatic apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    logic [LEVEL_BITS-1:0] lv;
    lv = data[LEVEL_BITS-1:0];
    if (lv > UNITY_Q16) begin
      lv = UNITY_Q16;
    end
    case (idx)
      REG_LEVEL_FIRST:       knob_first    = lv;
      REG_LEVEL_SECOND:      knob_second   = lv;
      REG_LIN_ENABLE_FIRST:  lin_on_first  = data[0];
      REG_EXP_ENABLE_FIRST:  exp_on_first  = data[0];
      REG_LIN_ENABLE_SECOND: lin_on_second = data[0];
      REG_EXP_ENABLE_SECOND: exp_on_second = data[0];
      default: ;
    endcase
  endtask

  task automatic note_failure(input string text);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("%s", text);
    end
  endtask

  // Result checking and prediction share one process so that, within an
  // edge, the oldest expectation is taken before a new one is added. Both
  // read the pre-edge values of the ports.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (out_expected_q.size() == 0) begin
        note_failure($sformatf("unexpected result %0d at cycle %0d",
                               out_audio_out, cycle_count));
      end else begin
        oldest = out_expected_q.pop_front();
        samples_checked++;
        if (out_audio_out !== oldest.audio_out) begin
          note_failure($sformatf(
            "audio_out mismatch: ch %0d in %0d lin %0d exp %0d: expected %0d, got %0d",
            oldest.second, oldest.audio, oldest.lin_cv, oldest.exp_cv,
            oldest.audio_out, out_audio_out));
        end
      end
    end
    if (rst_n && start && !busy) begin
      out_expected_q.push_back('{
        second:    in_channel_select,
        audio:     in_audio_in,
        lin_cv:    in_lin_voltage,
        exp_cv:    in_exp_voltage,
        audio_out: amplify(in_channel_select, in_audio_in,
                           in_lin_voltage, in_exp_voltage)});
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[dual_vca_linear_exponential_cv] ERROR");
      $finish;
    end
  end

  // Presents one voice sample from a falling edge and holds it until the
  // block takes it. Returns on the falling edge after acceptance with start
  // still high, so back-to-back transactions leave no hole.
  task automatic send_sample(input logic second, input sample_t x,
                             input cv_t lin_cv, input cv_t exp_cv);
    in_channel_select = second;
    in_audio_in       = x;
    in_lin_voltage    = lin_cv;
    in_exp_voltage    = exp_cv;
    start             = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  task automatic hold_sender(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Sender gap: mostly none or short, now and then a long one.
  task automatic random_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      return;
    end else if (pick < 85) begin
      hold_sender($urandom_range(1, 3));
    end else if (pick < 97) begin
      hold_sender($urandom_range(4, 12));
    end else begin
      hold_sender($urandom_range(20, 60));
    end
  endtask

  // Stops sending and waits for every outstanding result. Each transaction
  // gives exactly one result, so an empty queue means an empty pipeline.
  task automatic drain_results();
    start = 1'b0;
    while (out_expected_q.size() != 0) @(negedge clk);
  endtask

  // One register write on the configuration channel; only called while idle.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
    reg_write_count++;
  endtask

  function automatic cv_t random_cv();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      return cv_t'($urandom_range(0, 32767));
    end else if (pick < 7) begin
      return cv_t'($urandom);
    end else if (pick == 7) begin
      case ($urandom_range(0, 3))
        0:       return cv_t'(16'sh8000);
        1:       return cv_t'(-1);
        2:       return '0;
        default: return cv_t'(16'sh7fff);
      endcase
    end else begin
      return cv_t'($urandom_range(0, 255));
    end
  endfunction

  function automatic sample_t random_audio();
    case ($urandom_range(0, 15))
      0:       return sample_t'(16'sh8000);
      1:       return sample_t'(16'sh7fff);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Level write data, leaning on the edges: zero, one, unity and just below
  // it, and values above unity that must saturate.
  function automatic logic [CFG_DATA_BITS-1:0] random_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 17'd1;
      2:       return 17'd65535;
      3:       return 17'd65536;
      4:       return 17'd65537;
      5:       return 17'h1ffff;
      6:       return CFG_DATA_BITS'($urandom);
      default: return CFG_DATA_BITS'($urandom_range(0, 65536));
    endcase
  endfunction

  // Enable write data with random upper bits, which must be ignored.
  function automatic logic [CFG_DATA_BITS-1:0] enable_word(input logic on);
    return {16'($urandom), on};
  endfunction

  // Out of reset both levels are unity and every control voltage is off, so
  // samples come back unchanged whatever the voltages say.
  task automatic test_reset_defaults();
    send_sample(1'b0, sample_t'(16'sh7fff), random_cv(), random_cv());
    send_sample(1'b1, sample_t'(16'sh8000), random_cv(), random_cv());
    send_sample(1'b0, sample_t'(-1), random_cv(), random_cv());
    send_sample(1'b1, sample_t'(1), random_cv(), random_cv());
  endtask

  // Level registers alone: zero, saturation above unity, one step and just
  // below unity.
  task automatic test_level_registers();
    drain_results();
    write_reg(REG_LEVEL_FIRST, '0);
    write_reg(REG_LEVEL_SECOND, 17'h1ffff);
    send_sample(1'b0, sample_t'(16'sh7fff), '0, '0);
    send_sample(1'b1, sample_t'(16'sh8000), '0, '0);
    drain_results();
    write_reg(REG_LEVEL_FIRST, 17'd1);
    write_reg(REG_LEVEL_SECOND, 17'd65535);
    send_sample(1'b0, sample_t'(16'sh8000), '0, '0);
    send_sample(1'b1, sample_t'(16'sh7fff), '0, '0);
  endtask

  // Linear control voltage at its extremes, including negative values that
  // clamp to zero.
  task automatic test_linear_cv();
    drain_results();
    write_reg(REG_LEVEL_FIRST, 17'd65536);
    write_reg(REG_LEVEL_SECOND, 17'd65536);
    write_reg(REG_LIN_ENABLE_FIRST, 17'h10001);
    write_reg(REG_LIN_ENABLE_SECOND, 17'd1);
    send_sample(1'b0, sample_t'(16'sh7fff), cv_t'(16'sh8000), random_cv());
    send_sample(1'b1, sample_t'(16'sh8000), cv_t'(16'sh7fff), random_cv());
    send_sample(1'b0, sample_t'(16'sh8000), '0, random_cv());
    send_sample(1'b1, sample_t'(16'sh7fff), cv_t'(-1), random_cv());
    send_sample(1'b0, sample_t'(16'sh7fff), cv_t'(1), random_cv());
  endtask

  // Exponential control voltage: the ends of the curve, a segment boundary
  // and the start of the last segment. The linear enables are turned off by
  // data whose upper bits are set but whose bit 0 is clear.
  task automatic test_exponential_cv();
    drain_results();
    write_reg(REG_LIN_ENABLE_FIRST, 17'h1fffe);
    write_reg(REG_LIN_ENABLE_SECOND, 17'h1fffe);
    write_reg(REG_EXP_ENABLE_FIRST, 17'd1);
    write_reg(REG_EXP_ENABLE_SECOND, 17'd1);
    send_sample(1'b0, sample_t'(16'sh7fff), random_cv(), cv_t'(16'sh7fff));
    send_sample(1'b1, sample_t'(16'sh8000), random_cv(), cv_t'(16'sh7fff));
    send_sample(1'b0, sample_t'(16'sh7fff), random_cv(), cv_t'(16'sh8000));
    send_sample(1'b1, sample_t'(16'sh7fff), random_cv(), cv_t'(128));
    send_sample(1'b0, sample_t'(16'sh8000), random_cv(), cv_t'(127));
    send_sample(1'b1, sample_t'(16'sh7fff), random_cv(), cv_t'(32640));
  endtask

  // Writes to indexes past the register list must leave every setting alone.
  task automatic test_spare_indexes();
    drain_results();
    write_reg(REG_LIN_ENABLE_FIRST, 17'd1);
    write_reg(SPARE_INDEX_LOW, '0);
    write_reg(SPARE_INDEX_HIGH, '0);
    send_sample(1'b0, sample_t'(16'sh7fff), cv_t'(20000), cv_t'(30000));
    send_sample(1'b1, sample_t'(16'sh8000), cv_t'(20000), cv_t'(30000));
    send_sample($urandom_range(0, 1), random_audio(), random_cv(), random_cv());
  endtask

  // Random phases, each under a new register setting. The first two phases
  // pin the extremes: everything on at unity, then everything off at zero.
  // Each phase runs back to back or with random sender gaps, chosen at random.
  task automatic test_random_settings();
    logic back_to_back;
    logic all_on;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      if (phase < 2) begin
        all_on = (phase == 0);
        write_reg(REG_LEVEL_FIRST, all_on ? 17'd65536 : 17'd0);
        write_reg(REG_LEVEL_SECOND, all_on ? 17'd65536 : 17'd0);
        write_reg(REG_LIN_ENABLE_FIRST, enable_word(all_on));
        write_reg(REG_EXP_ENABLE_FIRST, enable_word(all_on));
        write_reg(REG_LIN_ENABLE_SECOND, enable_word(all_on));
        write_reg(REG_EXP_ENABLE_SECOND, enable_word(all_on));
      end else begin
        write_reg(REG_LEVEL_FIRST, random_level());
        write_reg(REG_LEVEL_SECOND, random_level());
        write_reg(REG_LIN_ENABLE_FIRST, enable_word($urandom_range(0, 1)));
        write_reg(REG_EXP_ENABLE_FIRST, enable_word($urandom_range(0, 1)));
        write_reg(REG_LIN_ENABLE_SECOND, enable_word($urandom_range(0, 1)));
        write_reg(REG_EXP_ENABLE_SECOND, enable_word($urandom_range(0, 1)));
      end
      setting_count++;
      back_to_back = $urandom_range(0, 1);
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        // Midway through one phase the sender waits for the pipeline to
        // empty completely before going on.
        if (phase == 3 && n == PHASE_SAMPLES / 2) begin
          drain_results();
        end
        send_sample($urandom_range(0, 1), random_audio(), random_cv(), random_cv());
        if (!back_to_back) begin
          random_gap();
        end
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_channel_select = 1'b0;
    in_audio_in       = '0;
    in_lin_voltage    = '0;
    in_exp_voltage    = '0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    error_count       = 0;
    samples_checked   = 0;
    reg_write_count   = 0;
    setting_count     = 0;
    cycle_count       = 0;
    apply_reg(REG_LEVEL_FIRST, 17'd65536);
    apply_reg(REG_LEVEL_SECOND, 17'd65536);
    apply_reg(REG_LIN_ENABLE_FIRST, '0);
    apply_reg(REG_EXP_ENABLE_FIRST, '0);
    apply_reg(REG_LIN_ENABLE_SECOND, '0);
    apply_reg(REG_EXP_ENABLE_SECOND, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_level_registers();
    test_linear_cv();
    test_exponential_cv();
    test_spare_indexes();
    test_random_settings();

    // Let the last results out, then watch a little longer for strays.
    drain_results();
    hold_sender(PIPE_LATENCY + 3);

    $display("Checked %0d samples on both channels over %0d random register settings",
             samples_checked, setting_count);
    $display("and %0d register writes, with saturating levels, spare indexes and negative CVs.",
             reg_write_count);
    if (error_count == 0) begin
      $display("[dual_vca_linear_exponential_cv] OK");
    end else begin
      $display("[dual_vca_linear_exponential_cv] ERROR");
    end
    $finish;
  end

endmodule
